### src/vpnd_pkg.sv
// ----------------------------------------------------------------------------
// vpnd_pkg
// shared types and fixed constants of the video packet nibble deframer
// ----------------------------------------------------------------------------
package vpnd_pkg;

  // fixed header layout
  localparam int HEADER_BYTES = 12;
  localparam int HDR_KEEP     = 7;     // header bytes 4..10 kept until the check
  localparam int HDR_FIRST    = 4;     // first header byte that is kept
  localparam int HDR_LPP      = 4;     // lines per packet
  localparam int HDR_BPP      = 4;     // bits per pixel
  localparam int HDR_ENC      = 0;     // encoding

  // field widths
  localparam int BYTE_W      = 8;
  localparam int NIBBLE_W    = 4;
  localparam int LINE_W      = 16;
  localparam int LINE_IDX_W  = 15;
  localparam int NTSC_W      = 15;
  localparam int PIX_ADDR_W  = 17;
  localparam int KIND_W      = 2;

  localparam logic [NTSC_W-1:0] NTSC_LAST_RST = 15'd236;

  typedef enum logic [KIND_W-1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_FRAME   = 2'd1,
    KIND_LEN_ERR = 2'd2
  } res_kind_t;

  typedef struct packed {
    res_kind_t               res_kind;
    logic                    buffer_sel;
    logic [PIX_ADDR_W-1:0]   pixel_addr;
    logic [NIBBLE_W-1:0]     pixel_lo;
    logic [NIBBLE_W-1:0]     pixel_hi;
    logic                    ntsc_frame;
    logic                    result_last;
  } vpnd_result_t;

  // results handed to the result queue in the same cycle, a before b
  typedef struct packed {
    logic wr_a;
    logic wr_b;
  } vpnd_push_t;

endpackage

### src/vpnd_in_if.sv
// ----------------------------------------------------------------------------
// vpnd_in_if
// byte channel into the deframer
// ----------------------------------------------------------------------------
interface vpnd_in_if;
  import vpnd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pkt_byte;
  logic              pkt_end;

  modport source (output valid, output pkt_byte, output pkt_end, input ready);
  modport sink   (input valid, input pkt_byte, input pkt_end, output ready);
endinterface

### src/vpnd_out_if.sv
// ----------------------------------------------------------------------------
// vpnd_out_if
// result channel out of the deframer
// ----------------------------------------------------------------------------
interface vpnd_out_if;
  import vpnd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     res_kind;
  logic                  buffer_sel;
  logic [PIX_ADDR_W-1:0] pixel_addr;
  logic [NIBBLE_W-1:0]   pixel_lo;
  logic [NIBBLE_W-1:0]   pixel_hi;
  logic                  ntsc_frame;
  logic                  result_last;

  modport source (output valid, output res_kind, output buffer_sel, output pixel_addr,
                  output pixel_lo, output pixel_hi, output ntsc_frame,
                  output result_last, input ready);
  modport sink   (input valid, input res_kind, input buffer_sel, input pixel_addr,
                  input pixel_lo, input pixel_hi, input ntsc_frame,
                  input result_last, output ready);
endinterface

### src/vpnd_cfg_if.sv
// ----------------------------------------------------------------------------
// vpnd_cfg_if
// write channel of the ntsc last line register
// ----------------------------------------------------------------------------
interface vpnd_cfg_if;
  import vpnd_pkg::*;

  logic              valid;
  logic              ready;
  logic [NTSC_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/video_packet_nibble_deframer.sv
// ----------------------------------------------------------------------------
// video_packet_nibble_deframer
// video datagram deframer: header check and 4-bit pixel pair writes
// ----------------------------------------------------------------------------
// Takes one datagram byte per clock on in_chan while the result queue has
// room and, when the 12-byte header passes its check, turns each payload byte
// whose pair fits in the frame into one pixel pair write for the current back
// buffer; the final byte may add a frame-complete event or a length error. An
// accepted byte is held in an input register and its results are registered
// in a two-entry result queue before they leave on out_chan. Sustained rate is
// one byte per cycle while out_chan keeps up; the only exception is a final
// byte that yields both a pixel write and an event, which needs the queue
// empty and so waits until the queue has drained. There is no clearing pass
// after reset. The ntsc last line register can be written at any time on
// cfg_chan but is meant to change only while no datagram is in flight.
// ----------------------------------------------------------------------------
module video_packet_nibble_deframer #(
  parameter int LINE_PIXELS   = 384,
  parameter int FRAME_LINES   = 272,
  parameter int PAYLOAD_BYTES = 768
) (
  input  logic        clk,
  input  logic        rst_n,
  vpnd_in_if.sink     in_chan,
  vpnd_out_if.source  out_chan,
  vpnd_cfg_if.sink    cfg_chan
);
  import vpnd_pkg::*;

  // ntsc last line register, always ready for a write transaction
  logic [NTSC_W-1:0] ntsc_last_r;

  // handoff from parser into the result queue
  vpnd_push_t   push;
  vpnd_result_t res_a;
  vpnd_result_t res_b;
  logic [1:0]   q_free;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ntsc_last_r <= NTSC_LAST_RST;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      ntsc_last_r <= cfg_chan.data;
    end
  end

  // byte register, header check, address counter, buffer flip
  vpnd_parser #(
    .LINE_PIXELS   (LINE_PIXELS),
    .FRAME_LINES   (FRAME_LINES),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .ntsc_last (ntsc_last_r),
    .q_free    (q_free),
    .push      (push),
    .res_a     (res_a),
    .res_b     (res_b)
  );

  // result register stage, holds up to two pending transactions
  vpnd_result_q u_result_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .res_a    (res_a),
    .res_b    (res_b),
    .q_free   (q_free),
    .out_chan (out_chan)
  );

endmodule

### src/vpnd_parser.sv
// ----------------------------------------------------------------------------
// vpnd_parser
// input register, header check, packet state and result generation
// ----------------------------------------------------------------------------
module vpnd_parser #(
  parameter int LINE_PIXELS   = 384,
  parameter int FRAME_LINES   = 272,
  parameter int PAYLOAD_BYTES = 768
) (
  input  logic                          clk,
  input  logic                          rst_n,
  vpnd_in_if.sink                       in_chan,
  input  logic [vpnd_pkg::NTSC_W-1:0]   ntsc_last,
  input  logic [1:0]                    q_free,
  output vpnd_pkg::vpnd_push_t          push,
  output vpnd_pkg::vpnd_result_t        res_a,
  output vpnd_pkg::vpnd_result_t        res_b
);
  import vpnd_pkg::*;

  localparam int PACKET_BYTES = HEADER_BYTES + PAYLOAD_BYTES;
  localparam int FRAME_PIXELS = LINE_PIXELS * FRAME_LINES;
  localparam int POS_W        = $clog2(PACKET_BYTES + 1);
  localparam int ADDR_W       = $clog2(FRAME_PIXELS + 2 * PAYLOAD_BYTES + 3);
  localparam int BASE_W       = LINE_IDX_W + $clog2(LINE_PIXELS + 1);

  // input register
  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_end_r;

  // packet state
  logic [POS_W-1:0]                 pos_r, pos_nxt;
  logic [HDR_KEEP-1:0][BYTE_W-1:0]  hdr_r, hdr_nxt;
  logic [LINE_W-1:0]                line_r, line_nxt;
  logic                             hv_r, hv_nxt;
  logic [ADDR_W-1:0]                addr_r, addr_nxt;
  logic                             back_buf_r, back_buf_nxt;

  logic              hdr_done, in_payload, hdr_ok, len_bad;
  logic              pix_emit, frame_emit, end_emit, advance;
  logic [LINE_W-1:0] line_hdr, ppl, enc, line_eff;
  logic              hv_eff;
  logic [BASE_W-1:0] base;
  logic [ADDR_W-1:0] base_sat;
  logic [1:0]        n_res;
  vpnd_result_t      pix_res, end_res;

  assign hdr_done   = (pos_r == POS_W'(HEADER_BYTES - 1));
  assign in_payload = (pos_r >= POS_W'(HEADER_BYTES)) && (pos_r < POS_W'(PACKET_BYTES));

  // header fields, encoding high byte comes in with the last header byte
  assign line_hdr = {hdr_r[1], hdr_r[0]};
  assign ppl      = {hdr_r[3], hdr_r[2]};
  assign enc      = {in_byte_r, hdr_r[6]};
  assign hdr_ok   = (ppl == LINE_W'(LINE_PIXELS)) && (hdr_r[4] == BYTE_W'(HDR_LPP)) &&
                    (hdr_r[5] == BYTE_W'(HDR_BPP)) && (enc == LINE_W'(HDR_ENC));

  assign base     = BASE_W'(line_hdr[LINE_IDX_W-1:0]) * BASE_W'(LINE_PIXELS);
  assign base_sat = (base > BASE_W'(FRAME_PIXELS)) ? ADDR_W'(FRAME_PIXELS) : ADDR_W'(base);

  assign hv_eff   = hdr_done ? hdr_ok : hv_r;
  assign line_eff = hdr_done ? line_hdr : line_r;

  assign pix_emit   = in_payload && hv_r &&
                      ((addr_r + ADDR_W'(2)) <= ADDR_W'(FRAME_PIXELS));
  assign len_bad    = (pos_r != POS_W'(PACKET_BYTES - 1));
  assign frame_emit = in_end_r && !len_bad && hv_eff && line_eff[LINE_W-1];
  assign end_emit   = in_end_r && (len_bad || frame_emit);

  assign n_res   = {1'b0, pix_emit} + {1'b0, end_emit};
  assign advance = in_vld_r && (n_res <= q_free);

  assign in_chan.ready = !in_vld_r || advance;

  always_comb begin
    pix_res             = '0;
    pix_res.res_kind    = KIND_PIXEL;
    pix_res.buffer_sel  = back_buf_r;
    pix_res.pixel_addr  = PIX_ADDR_W'(addr_r);
    pix_res.pixel_lo    = in_byte_r[NIBBLE_W-1:0];
    pix_res.pixel_hi    = in_byte_r[BYTE_W-1:NIBBLE_W];
    pix_res.result_last = !end_emit;

    end_res             = '0;
    end_res.res_kind    = len_bad ? KIND_LEN_ERR : KIND_FRAME;
    end_res.buffer_sel  = back_buf_r;
    end_res.ntsc_frame  = !len_bad && (line_eff == {1'b1, ntsc_last});
    end_res.result_last = 1'b1;
  end

  assign res_a     = pix_emit ? pix_res : end_res;
  assign res_b     = end_res;
  assign push.wr_a = advance && (pix_emit || end_emit);
  assign push.wr_b = advance && pix_emit && end_emit;

  always_comb begin
    pos_nxt      = pos_r;
    hdr_nxt      = hdr_r;
    line_nxt     = line_r;
    hv_nxt       = hv_r;
    addr_nxt     = addr_r;
    back_buf_nxt = back_buf_r;
    if (advance) begin
      for (int k = 0; k < HDR_KEEP; k++) begin
        if (pos_r == POS_W'(HDR_FIRST + k)) begin
          hdr_nxt[k] = in_byte_r;
        end
      end
      if (hdr_done) begin
        hv_nxt   = hdr_ok;
        line_nxt = line_hdr;
        addr_nxt = base_sat;
      end else if (in_payload) begin
        addr_nxt = addr_r + ADDR_W'(2);
      end
      if (in_end_r) begin
        if (frame_emit) begin
          back_buf_nxt = !back_buf_r;
        end
        pos_nxt  = '0;
        hdr_nxt  = '0;
        line_nxt = '0;
        hv_nxt   = 1'b0;
        addr_nxt = '0;
      end else if (pos_r < POS_W'(PACKET_BYTES)) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      pos_r      <= '0;
      hdr_r      <= '0;
      line_r     <= '0;
      hv_r       <= 1'b0;
      addr_r     <= '0;
      back_buf_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        in_vld_r <= in_chan.valid;
      end
      pos_r      <= pos_nxt;
      hdr_r      <= hdr_nxt;
      line_r     <= line_nxt;
      hv_r       <= hv_nxt;
      addr_r     <= addr_nxt;
      back_buf_r <= back_buf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_byte_r <= in_chan.pkt_byte;
      in_end_r  <= in_chan.pkt_end;
    end
  end

  // two results only come from the final byte of a datagram
  a_two_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    push.wr_b |-> in_end_r)
    else $error("two results from a byte that does not end the datagram");

  // the back buffer flips exactly when a frame completes
  a_flip_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && frame_emit) |=> (back_buf_r != $past(back_buf_r)))
    else $error("back buffer did not toggle after frame complete");

  // the end of a datagram restarts the byte count
  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_end_r) |=> (pos_r == '0))
    else $error("byte position not cleared at end of datagram");

endmodule

### src/vpnd_result_q.sv
// ----------------------------------------------------------------------------
// vpnd_result_q
// two-entry result queue in front of the result channel
// ----------------------------------------------------------------------------
module vpnd_result_q (
  input  logic                   clk,
  input  logic                   rst_n,
  input  vpnd_pkg::vpnd_push_t   push,
  input  vpnd_pkg::vpnd_result_t res_a,
  input  vpnd_pkg::vpnd_result_t res_b,
  output logic [1:0]             q_free,
  vpnd_out_if.source             out_chan
);
  import vpnd_pkg::*;

  vpnd_result_t head_r, head_nxt;
  vpnd_result_t tail_r, tail_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic [1:0]   cnt_pop;
  logic         pop;

  assign pop     = out_chan.valid && out_chan.ready;
  assign cnt_pop = cnt_r - {1'b0, pop};
  // free space counts only what is already stored, so ready never waits on out ready
  assign q_free  = 2'd2 - cnt_r;

  always_comb begin
    head_nxt = pop ? tail_r : head_r;
    tail_nxt = tail_r;
    if (push.wr_a) begin
      if (cnt_pop == 2'd0) begin
        head_nxt = res_a;
      end else begin
        tail_nxt = res_a;
      end
    end
    if (push.wr_b) begin
      tail_nxt = res_b;
    end
    cnt_nxt = cnt_pop + {1'b0, push.wr_a} + {1'b0, push.wr_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  assign out_chan.valid       = (cnt_r != 2'd0);
  assign out_chan.res_kind    = head_r.res_kind;
  assign out_chan.buffer_sel  = head_r.buffer_sel;
  assign out_chan.pixel_addr  = head_r.pixel_addr;
  assign out_chan.pixel_lo    = head_r.pixel_lo;
  assign out_chan.pixel_hi    = head_r.pixel_hi;
  assign out_chan.ntsc_frame  = head_r.ntsc_frame;
  assign out_chan.result_last = head_r.result_last;

  // the parser never pushes more than there is room for
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !push.wr_a)
    else $error("result pushed into a full queue");

  a_pair_fits: assert property (@(posedge clk) disable iff (!rst_n)
    push.wr_b |-> (push.wr_a && cnt_r == 2'd0))
    else $error("result pair pushed without room");

endmodule

### dv/video_packet_nibble_deframer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// video_packet_nibble_deframer_test
// self-checking testbench of the video packet nibble deframer
// ----------------------------------------------------------------------------
// Feeds datagrams byte by byte and checks every result transaction against a
// behavioral predictor kept in step with each accepted byte. A short table of
// hand-written bytes opens the run, then several phases, each with its own
// ntsc last line setting, send random datagrams cut short at various points:
// ones with a good header, ones with a broken header and plain noise. Both
// channels idle at random, and the result side holds off once for a long
// stretch.
// ----------------------------------------------------------------------------
module video_packet_nibble_deframer_test;
  import vpnd_pkg::*;

  // block geometry, the default configuration of the deframer
  localparam int LINE_PIXELS   = 384;
  localparam int FRAME_LINES   = 272;
  localparam int PAYLOAD_BYTES = 768;
  localparam int FRAME_PIXELS  = LINE_PIXELS * FRAME_LINES;
  localparam int PACKET_BYTES  = HEADER_BYTES + PAYLOAD_BYTES;

  // run control
  localparam int DRAIN_CYCLES = 16;       // input register plus result queue, with margin
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_AFTER   = 30;       // results checked before the long hold-off
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 4;
  localparam int PHASE_SHAPES = 5;        // random datagrams per phase

  typedef enum {
    SHAPE_SHORT,
    SHAPE_BAD_HDR,
    SHAPE_NOISE
  } dgram_shape_t;

  // result-side stall patterns, switched by bits 8:7 of the result-side cycle counter
  typedef enum logic [1:0] {
    RX_OPEN  = 2'd0,
    RX_LIGHT = 2'd1,
    RX_COMB  = 2'd2,
    RX_HEAVY = 2'd3
  } rx_pattern_t;

  // one row of the opening table: a byte and, where it is obvious, its results
  localparam logic [1:0] ROW_PREDICT = 2'd3;   // results come from the predictor

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              fin;
    logic [1:0]        n_typed;
    vpnd_result_t      res_a;
    vpnd_result_t      res_b;
  } stim_row_t;

  localparam vpnd_result_t NO_RESULT = '0;
  localparam vpnd_result_t LEN_ERR_B0 =
    '{KIND_LEN_ERR, 1'b0, 17'd0, 4'h0, 4'h0, 1'b0, 1'b1};
  localparam vpnd_result_t WR_ADDR0 =
    '{KIND_PIXEL, 1'b0, 17'd0, 4'h0, 4'hF, 1'b0, 1'b1};
  localparam vpnd_result_t WR_ADDR2 =
    '{KIND_PIXEL, 1'b0, 17'd2, 4'hF, 4'h0, 1'b0, 1'b0};

  localparam int N_DIRECTED = 19;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // one-byte datagrams right after reset: length errors only
    '{8'hFF, 1'b1, 2'd1, LEN_ERR_B0, NO_RESULT},
    '{8'h00, 1'b1, 2'd1, LEN_ERR_B0, NO_RESULT},
    // good header, line 0: sequence, frame, line
    '{8'hFF, 1'b0, ROW_PREDICT, NO_RESULT, NO_RESULT},
    '{8'h00, 1'b0, ROW_PREDICT, NO_RESULT, NO_RESULT},
    '{8'h00, 1'b0, ROW_PREDICT, NO_RESULT, NO_RESULT},
    '{8'hFF, 1'b0, ROW_PREDICT, NO_RESULT, NO_RESULT},
    '{8'h00, 1'b0, ROW_PREDICT, NO_RESULT, NO_RESULT},
    '{8'h00, 1'b0, ROW_PREDICT, NO_RESULT, NO_RESULT},
    // pixels per line, lines per packet, bits per pixel, encoding
    '{8'(LINE_PIXELS), 1'b0, ROW_PREDICT, NO_RESULT, NO_RESULT},
    '{8'(LINE_PIXELS >> 8), 1'b0, ROW_PREDICT, NO_RESULT, NO_RESULT},
    '{8'(HDR_LPP), 1'b0, ROW_PREDICT, NO_RESULT, NO_RESULT},
    '{8'(HDR_BPP), 1'b0, ROW_PREDICT, NO_RESULT, NO_RESULT},
    '{8'(HDR_ENC), 1'b0, ROW_PREDICT, NO_RESULT, NO_RESULT},
    '{8'(HDR_ENC >> 8), 1'b0, ROW_PREDICT, NO_RESULT, NO_RESULT},
    // two payload bytes with nibble extremes, then the datagram is cut short
    '{8'hF0, 1'b0, 2'd1, WR_ADDR0, NO_RESULT},
    '{8'h0F, 1'b1, 2'd2, WR_ADDR2, LEN_ERR_B0},
    // datagram that ends inside its header
    '{8'h12, 1'b0, ROW_PREDICT, NO_RESULT, NO_RESULT},
    '{8'h34, 1'b0, ROW_PREDICT, NO_RESULT, NO_RESULT},
    '{8'h56, 1'b1, 2'd1, LEN_ERR_B0, NO_RESULT}
  };

  logic clk = 1'b0;
  logic rst_n;

  vpnd_in_if  in_chan ();
  vpnd_out_if out_chan ();
  vpnd_cfg_if cfg_chan ();

  video_packet_nibble_deframer #(
    .LINE_PIXELS  (LINE_PIXELS),
    .FRAME_LINES  (FRAME_LINES),
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // deframer predictor state
  // --------------------------------------------------------------------------
  int unsigned       dg_pos      = 0;      // bytes seen in the current datagram
  logic [63:0]       dg_hdr      = '0;     // header bytes 4..11
  logic [LINE_W-1:0] dg_line     = '0;
  bit                dg_hdr_ok   = 1'b0;
  int unsigned       dg_base     = 0;      // line offset, saturated at the frame size
  logic              back_buf    = 1'b0;
  logic [NTSC_W-1:0] ntsc_last   = NTSC_LAST_RST;

  vpnd_result_t expected_results [$];
  vpnd_result_t byte_results [$];          // results of the byte just accepted

  // sender pacing
  int burst_left = 8;
  int idle_gap   = 0;

  // result side
  int results_checked = 0;
  int mismatches      = 0;
  int hold_left       = 0;
  bit hold_done       = 1'b0;
  logic [31:0] rx_cycle = '0;
  int cycle_count = 0;

  function automatic vpnd_result_t make_result(res_kind_t kind, logic [PIX_ADDR_W-1:0] addr,
                                               logic [NIBBLE_W-1:0] lo,
                                               logic [NIBBLE_W-1:0] hi, logic ntsc);
    vpnd_result_t r;
    r.res_kind    = kind;
    r.buffer_sel  = back_buf;
    r.pixel_addr  = addr;
    r.pixel_lo    = lo;
    r.pixel_hi    = hi;
    r.ntsc_frame  = ntsc;
    r.result_last = 1'b0;
    return r;
  endfunction

  // advance the predictor by one accepted byte, leaving its results in byte_results
  task automatic deframe_predict(input logic [BYTE_W-1:0] b, input logic fin);
    int unsigned       p;
    int unsigned       base;
    int unsigned       addr;
    logic [LINE_W-1:0] line;
    vpnd_result_t      r [2];
    int                n;
    p = dg_pos;
    n = 0;
    byte_results.delete();

    if (p >= HDR_FIRST && p < HEADER_BYTES)
      dg_hdr[8*(p-HDR_FIRST) +: 8] = b;

    if (p == HEADER_BYTES - 1) begin
      // last header byte: run the header check and fix the line offset
      line = dg_hdr[15:0];
      dg_hdr_ok = dg_hdr[31:16] == 16'(LINE_PIXELS) && dg_hdr[39:32] == 8'(HDR_LPP) &&
                  dg_hdr[47:40] == 8'(HDR_BPP) && dg_hdr[63:48] == 16'(HDR_ENC);
      dg_line = line;
      base = 32'(line[LINE_IDX_W-1:0]) * 32'(LINE_PIXELS);
      dg_base = base > FRAME_PIXELS ? FRAME_PIXELS : base;
    end else if (p >= HEADER_BYTES && p < PACKET_BYTES && dg_hdr_ok) begin
      addr = dg_base + 2 * (p - HEADER_BYTES);
      // pairs past the frame store are dropped
      if (addr + 2 <= FRAME_PIXELS) begin
        r[n] = make_result(KIND_PIXEL, addr[PIX_ADDR_W-1:0], b[3:0], b[7:4], 1'b0);
        n++;
      end
    end

    if (fin) begin
      if (p + 1 != PACKET_BYTES) begin
        r[n] = make_result(KIND_LEN_ERR, '0, '0, '0, 1'b0);
        n++;
      end else if (dg_hdr_ok && dg_line[LINE_W-1]) begin
        r[n] = make_result(KIND_FRAME, '0, '0, '0, dg_line == {1'b1, ntsc_last});
        n++;
        back_buf = ~back_buf;
      end
      dg_pos    = 0;
      dg_hdr    = '0;
      dg_line   = '0;
      dg_hdr_ok = 1'b0;
      dg_base   = 0;
    end else begin
      dg_pos = p < PACKET_BYTES ? p + 1 : PACKET_BYTES;
    end

    if (n > 0)
      r[n-1].result_last = 1'b1;
    for (int i = 0; i < n; i++)
      byte_results.push_back(r[i]);
  endtask

  // --------------------------------------------------------------------------
  // byte channel driver
  // --------------------------------------------------------------------------
  // offers one byte, waits for the transaction, then maybe opens an idle gap
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
    if (idle_gap > 0) begin
      repeat (idle_gap) @(posedge clk);
      idle_gap = 0;
    end
    in_chan.valid    <= 1'b1;
    in_chan.pkt_byte <= b;
    in_chan.pkt_end  <= fin;
    do @(posedge clk); while (!in_chan.ready);
    deframe_predict(b, fin);
    burst_left = burst_left - 1;
    if (burst_left <= 0) begin
      in_chan.valid <= 1'b0;
      idle_gap = $urandom_range(1, 6);
      // now and then a long burst with no gaps at all
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(200, 400)
                                              : $urandom_range(1, 24);
    end
  endtask

  task automatic send_and_predict(input logic [BYTE_W-1:0] b, input logic fin);
    send_byte(b, fin);
    foreach (byte_results[i])
      expected_results.push_back(byte_results[i]);
  endtask

  // line word for a new datagram: mostly inside the frame, some near or past
  // its end, some matching the ntsc last line
  function automatic logic [LINE_W-1:0] pick_line();
    int unsigned pick;
    logic        top;
    pick = $urandom_range(0, 9);
    top  = 1'($urandom);
    if (pick < 4)
      return {top, 15'($urandom_range(0, FRAME_LINES - 1))};
    else if (pick < 6)
      return {top, 15'($urandom_range(FRAME_LINES - 8, FRAME_LINES + 4))};
    else if (pick < 8)
      return {top, 15'($urandom)};
    return {1'b1, ntsc_last};
  endfunction

  function automatic dgram_shape_t random_shape();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return SHAPE_SHORT;
    else if (r < 75)
      return SHAPE_BAD_HDR;
    return SHAPE_NOISE;
  endfunction

  task automatic send_datagram(input dgram_shape_t shape);
    logic [BYTE_W-1:0] hdr [HEADER_BYTES];
    logic [LINE_W-1:0] line;
    logic [15:0]       ppl;
    logic [15:0]       enc;
    logic [7:0]        lpp;
    logic [7:0]        bpp;
    int unsigned       len;
    line = pick_line();
    ppl  = 16'(LINE_PIXELS);
    lpp  = 8'(HDR_LPP);
    bpp  = 8'(HDR_BPP);
    enc  = 16'(HDR_ENC);
    case (shape)
      SHAPE_SHORT: len = $urandom_range(1, 40);
      SHAPE_BAD_HDR: begin
        // spoil one header field, keep the header complete
        case ($urandom_range(0, 3))
          0:       ppl = ppl ^ 16'($urandom_range(1, 16'hFFFF));
          1:       lpp = lpp ^ 8'($urandom_range(1, 8'hFF));
          2:       bpp = bpp ^ 8'($urandom_range(1, 8'hFF));
          default: enc = enc ^ 16'($urandom_range(1, 16'hFFFF));
        endcase
        len = $urandom_range(HEADER_BYTES, 40);
      end
      default: len = $urandom_range(1, 24);
    endcase
    hdr[0]  = 8'($urandom);
    hdr[1]  = 8'($urandom);
    hdr[2]  = 8'($urandom);
    hdr[3]  = 8'($urandom);
    hdr[4]  = line[7:0];
    hdr[5]  = line[15:8];
    hdr[6]  = ppl[7:0];
    hdr[7]  = ppl[15:8];
    hdr[8]  = lpp;
    hdr[9]  = bpp;
    hdr[10] = enc[7:0];
    hdr[11] = enc[15:8];
    if (shape == SHAPE_NOISE)
      foreach (hdr[i]) hdr[i] = 8'($urandom);
    for (int unsigned i = 0; i < len; i++)
      send_and_predict(i < HEADER_BYTES ? hdr[i] : 8'($urandom), i == len - 1);
  endtask

  // stop offering, let every expected result drain, then let the pipe settle
  task automatic quiesce();
    if (idle_gap == 0)
      in_chan.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_ntsc_last(input logic [NTSC_W-1:0] v);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= v;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    ntsc_last = v;
  endtask

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    vpnd_result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result transaction, kind %0d addr %0d",
             out_chan.res_kind, out_chan.pixel_addr);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      check_field("res_kind", want.res_kind, out_chan.res_kind);
      check_field("buffer_sel", want.buffer_sel, out_chan.buffer_sel);
      check_field("pixel_addr", want.pixel_addr, out_chan.pixel_addr);
      check_field("pixel_lo", want.pixel_lo, out_chan.pixel_lo);
      check_field("pixel_hi", want.pixel_hi, out_chan.pixel_hi);
      check_field("ntsc_frame", want.ntsc_frame, out_chan.ntsc_frame);
      check_field("result_last", want.result_last, out_chan.result_last);
    end
    results_checked++;
  endtask

  // result side: checks each transaction and stalls on its own pattern,
  // with one long hold-off so the result queue fills and in_chan stalls
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready)
        check_result();
      rx_cycle++;
      if (!hold_done && results_checked >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (!rst_n) begin
        out_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else begin
        case (rx_pattern_t'(rx_cycle[8:7]))
          RX_OPEN:  out_chan.ready <= 1'b1;
          RX_LIGHT: out_chan.ready <= $urandom_range(0, 3) != 0;
          RX_COMB:  out_chan.ready <= rx_cycle[2:0] != 3'd5 && rx_cycle[2:0] != 3'd6;
          default:  out_chan.ready <= $urandom_range(0, 9) < 3;
        endcase
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  stim_row_t row;

  initial begin
    rst_n            <= 1'b0;
    in_chan.valid    <= 1'b0;
    in_chan.pkt_byte <= '0;
    in_chan.pkt_end  <= 1'b0;
    cfg_chan.valid   <= 1'b0;
    cfg_chan.data    <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // opening table; typed rows carry their results, the rest are predicted
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      send_byte(row.data, row.fin);
      if (row.n_typed == ROW_PREDICT) begin
        foreach (byte_results[k])
          expected_results.push_back(byte_results[k]);
      end else begin
        if (row.n_typed >= 2'd1)
          expected_results.push_back(row.res_a);
        if (row.n_typed == 2'd2)
          expected_results.push_back(row.res_b);
      end
    end
    quiesce();

    // phases: reset value, both extremes, then a random setting
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       ;
        1:       write_ntsc_last('0);
        2:       write_ntsc_last('1);
        default: write_ntsc_last(NTSC_W'($urandom));
      endcase
      repeat (PHASE_SHAPES) send_datagram(random_shape());
      quiesce();
    end

    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
